FILE: hdl/afp_pkg.sv
// ----------------------------------------------------------------------------
// afp_pkg
// Shared types and constants of the adaptive feasibility penalty unit:
// item structs, mode and register codes, and fixed-point penalty bounds.
// ----------------------------------------------------------------------------
package afp_pkg;

  localparam int FRACTION_BITS     = 16;
  localparam int PEN_W             = 10 + FRACTION_BITS;
  localparam int COUNT_OUT_W       = 7;
  localparam int TARGET_W          = 7;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = PEN_W;
  localparam int WINDOW_LENGTH_DEF = 100;

  localparam logic [PEN_W-1:0] PEN_ONE   = PEN_W'(64'd1 << FRACTION_BITS);
  localparam logic [PEN_W-1:0] PEN_CAP   = PEN_W'(64'd1000 << FRACTION_BITS);
  localparam logic [PEN_W-1:0] PEN_FLOOR = PEN_W'(((64'd1 << FRACTION_BITS) + 64'd5) / 64'd10);

  localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(20);

  // Item modes; the fourth code is unused and leaves the state unchanged.
  localparam logic [1:0] MODE_RECORD  = 2'd0;
  localparam logic [1:0] MODE_MANAGE  = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_CAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_DUR = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic       load_ok;
    logic       duration_ok;
  } afp_in_t;

  typedef struct packed {
    logic [PEN_W-1:0]       capacity_penalty_out;
    logic [PEN_W-1:0]       duration_penalty_out;
    logic [COUNT_OUT_W-1:0] load_feasible_count;
    logic [COUNT_OUT_W-1:0] duration_feasible_count;
  } afp_out_t;

  // Strobes for the accepted item, at most one set (none for the unused mode).
  typedef struct packed {
    logic record;
    logic manage;
    logic restart;
  } afp_cmd_t;

endpackage

FILE: hdl/afp_ram.sv
// ----------------------------------------------------------------------------
// afp_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module afp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/afp_window.sv
// ----------------------------------------------------------------------------
// afp_window
// Load and duration flag windows held in one RAM, with the write pointer,
// the running counts of ones and a wrap flag standing in for the refill.
// ----------------------------------------------------------------------------
module afp_window #(
  parameter int WINDOW_LENGTH = afp_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  afp_pkg::afp_cmd_t                  cmd,
  input  logic                               load_ok,
  input  logic                               duration_ok,
  output logic [$clog2(WINDOW_LENGTH+1)-1:0] load_cnt,
  output logic [$clog2(WINDOW_LENGTH+1)-1:0] dur_cnt,
  output logic [$clog2(WINDOW_LENGTH+1)-1:0] load_cnt_nxt,
  output logic [$clog2(WINDOW_LENGTH+1)-1:0] dur_cnt_nxt
);
  import afp_pkg::*;

  localparam int AW    = $clog2(WINDOW_LENGTH);
  localparam int CNT_W = $clog2(WINDOW_LENGTH + 1);

  logic [AW-1:0]    ptr_r, ptr_nxt, rd_addr;
  logic             wrapped_r, wrapped_nxt;
  logic [CNT_W-1:0] load_cnt_r, dur_cnt_r;
  logic [1:0]       rd_flags;
  logic             old_load, old_dur;

  // The RAM is read every cycle at the pointer of the next cycle, so its
  // output always holds the slot that the next record overwrites. Until the
  // pointer has wrapped once after a restart, that slot still counts as one.
  assign old_load = wrapped_r ? rd_flags[1] : 1'b1;
  assign old_dur  = wrapped_r ? rd_flags[0] : 1'b1;

  always_comb begin
    ptr_nxt      = ptr_r;
    wrapped_nxt  = wrapped_r;
    load_cnt_nxt = load_cnt_r;
    dur_cnt_nxt  = dur_cnt_r;
    if (cmd.restart) begin
      ptr_nxt      = '0;
      wrapped_nxt  = 1'b0;
      load_cnt_nxt = CNT_W'(WINDOW_LENGTH);
      dur_cnt_nxt  = CNT_W'(WINDOW_LENGTH);
    end else if (cmd.record) begin
      load_cnt_nxt = load_cnt_r - CNT_W'(old_load) + CNT_W'(load_ok);
      dur_cnt_nxt  = dur_cnt_r - CNT_W'(old_dur) + CNT_W'(duration_ok);
      if (ptr_r == AW'(WINDOW_LENGTH - 1)) begin
        ptr_nxt     = '0;
        wrapped_nxt = 1'b1;
      end else begin
        ptr_nxt = ptr_r + AW'(1);
      end
    end
  end

  assign rd_addr = rst_n ? ptr_nxt : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r      <= '0;
      wrapped_r  <= 1'b0;
      load_cnt_r <= CNT_W'(WINDOW_LENGTH);
      dur_cnt_r  <= CNT_W'(WINDOW_LENGTH);
    end else begin
      ptr_r      <= ptr_nxt;
      wrapped_r  <= wrapped_nxt;
      load_cnt_r <= load_cnt_nxt;
      dur_cnt_r  <= dur_cnt_nxt;
    end
  end

  afp_ram #(
    .WIDTH (2),
    .DEPTH (WINDOW_LENGTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.record),
    .wr_addr (ptr_r),
    .wr_data ({load_ok, duration_ok}),
    .rd_addr (rd_addr),
    .rd_data (rd_flags)
  );

  assign load_cnt = load_cnt_r;
  assign dur_cnt  = dur_cnt_r;

endmodule

FILE: hdl/afp_penalty.sv
// ----------------------------------------------------------------------------
// afp_penalty
// One penalty register with its window test and the raise-by-1.2 or
// lower-by-0.85 update, rounded half up and held within floor and cap.
// ----------------------------------------------------------------------------
module afp_penalty #(
  parameter int WINDOW_LENGTH = afp_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  afp_pkg::afp_cmd_t                  cmd,
  input  logic [afp_pkg::TARGET_W-1:0]       target,
  input  logic [afp_pkg::PEN_W-1:0]          init_pen,
  input  logic [$clog2(WINDOW_LENGTH+1)-1:0] cnt,
  output logic [afp_pkg::PEN_W-1:0]          pen_nxt
);
  import afp_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_LENGTH + 1);
  localparam int CMP_W = $clog2(132 * WINDOW_LENGTH + 1);
  // Numerators stay below 2^NUM_W; a reciprocal with DIV_K fraction bits
  // gives the exact quotient by ten over that range.
  localparam int NUM_W = PEN_W + 4;
  localparam int DIV_K = NUM_W + 4;
  localparam int M_W   = DIV_K - 3;
  localparam logic [63:0] DIV_M_FULL = ((64'd1 << DIV_K) + 64'd9) / 64'd10;
  localparam logic [M_W-1:0] DIV_M = DIV_M_FULL[M_W-1:0];

  logic [PEN_W-1:0] pen_r;
  logic [CMP_W-1:0] c100, tw, five_w;
  logic             too_low, too_high, raise, lower;
  logic [NUM_W-1:0] raise_num, lower_num, num;
  logic [NUM_W:0]   lower_full;
  logic [NUM_W+M_W-1:0] prod;
  logic [PEN_W:0]   quot;
  logic [PEN_W-1:0] adj, init_clamped;

  assign five_w   = CMP_W'(5 * WINDOW_LENGTH);
  assign c100     = CMP_W'(cnt) * CMP_W'(100);
  assign tw       = CMP_W'(target) * CMP_W'(WINDOW_LENGTH);
  assign too_low  = (c100 + five_w) < tw;
  assign too_high = c100 > (tw + five_w);
  assign raise    = too_low && (pen_r < PEN_CAP);
  assign lower    = too_high && (pen_r > PEN_FLOOR);

  // 12p + 5 over ten, or (17p + 10) / 2 over ten, which equals over twenty.
  assign raise_num  = (NUM_W'(pen_r) << 3) + (NUM_W'(pen_r) << 2) + NUM_W'(5);
  assign lower_full = ((NUM_W+1)'(pen_r) << 4) + (NUM_W+1)'(pen_r) + (NUM_W+1)'(10);
  assign lower_num  = lower_full[NUM_W:1];
  assign num        = raise ? raise_num : lower_num;
  assign prod       = (NUM_W+M_W)'(num) * (NUM_W+M_W)'(DIV_M);
  assign quot       = prod[DIV_K+PEN_W:DIV_K];

  always_comb begin
    adj = pen_r;
    if (raise) begin
      adj = (quot > (PEN_W+1)'(PEN_CAP)) ? PEN_CAP : quot[PEN_W-1:0];
    end else if (lower) begin
      adj = (quot < (PEN_W+1)'(PEN_FLOOR)) ? PEN_FLOOR : quot[PEN_W-1:0];
    end
  end

  always_comb begin
    if (init_pen > PEN_CAP) begin
      init_clamped = PEN_CAP;
    end else if (init_pen < PEN_FLOOR) begin
      init_clamped = PEN_FLOOR;
    end else begin
      init_clamped = init_pen;
    end
  end

  always_comb begin
    pen_nxt = pen_r;
    if (cmd.restart) begin
      pen_nxt = init_clamped;
    end else if (cmd.manage) begin
      pen_nxt = adj;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r <= PEN_ONE;
    end else begin
      pen_r <= pen_nxt;
    end
  end

endmodule

FILE: hdl/adaptive_feasibility_penalty_unit.sv
// ----------------------------------------------------------------------------
// adaptive_feasibility_penalty_unit
// Sliding-window feasibility tracking with adaptive capacity and duration
// penalties.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_ready, in_data) takes one item per
// cycle: record shifts a load and a duration flag into the windows, manage
// adjusts both penalties from the window counts, restart refills the windows
// with ones and loads the clamped initial penalties. Every item gives exactly
// one result on the output channel (out_valid, out_ready, out_data) showing
// the penalties and counts after that item.
// out_valid is set in the cycle after acceptance; one item is taken per
// cycle while the output is not stalled, as the penalty and count registers
// update with each item and the window RAM, with one read and one write
// port, is read ahead at the next pointer.
// The output register holds a result until it is taken. While it is full and
// out_ready is low, in_ready is low; when it is taken, a new item enters in
// the same cycle.
// Reset (rst_n low, synchronous) empties the output register, returns the
// counts to the window length, the pointer to zero and the penalties to 1.0;
// no clearing pass runs, as window slots count as ones until first rewritten.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) are registered.
// ----------------------------------------------------------------------------
module adaptive_feasibility_penalty_unit #(
  parameter int WINDOW_LENGTH = afp_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  afp_pkg::afp_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output afp_pkg::afp_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [afp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import afp_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_LENGTH + 1);

  logic [TARGET_W-1:0] target_r;
  logic [PEN_W-1:0]    init_cap_r, init_dur_r;
  logic                accept;
  afp_cmd_t            cmd;
  logic [CNT_W-1:0]    load_cnt, dur_cnt, load_cnt_nxt, dur_cnt_nxt;
  logic [PEN_W-1:0]    cap_pen_nxt, dur_pen_nxt;
  logic [CNT_W+COUNT_OUT_W-1:0] load_ext, dur_ext;
  logic                out_valid_r, out_valid_nxt;
  afp_out_t            out_data_r, out_data_nxt;

  assign in_ready = rst_n && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  assign cmd.record  = accept && (in_data.mode == MODE_RECORD);
  assign cmd.manage  = accept && (in_data.mode == MODE_MANAGE);
  assign cmd.restart = accept && (in_data.mode == MODE_RESTART);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r   <= TARGET_RESET;
      init_cap_r <= PEN_ONE;
      init_dur_r <= PEN_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET:   target_r   <= cfg_wdata[TARGET_W-1:0];
        CFG_INIT_CAP: init_cap_r <= cfg_wdata[PEN_W-1:0];
        CFG_INIT_DUR: init_dur_r <= cfg_wdata[PEN_W-1:0];
        default: ;
      endcase
    end
  end

  afp_window #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .load_ok      (in_data.load_ok),
    .duration_ok  (in_data.duration_ok),
    .load_cnt     (load_cnt),
    .dur_cnt      (dur_cnt),
    .load_cnt_nxt (load_cnt_nxt),
    .dur_cnt_nxt  (dur_cnt_nxt)
  );

  afp_penalty #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_cap_pen (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .target   (target_r),
    .init_pen (init_cap_r),
    .cnt      (load_cnt),
    .pen_nxt  (cap_pen_nxt)
  );

  afp_penalty #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_dur_pen (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .target   (target_r),
    .init_pen (init_dur_r),
    .cnt      (dur_cnt),
    .pen_nxt  (dur_pen_nxt)
  );

  assign load_ext = {{COUNT_OUT_W{1'b0}}, load_cnt_nxt};
  assign dur_ext  = {{COUNT_OUT_W{1'b0}}, dur_cnt_nxt};

  always_comb begin
    out_data_nxt.capacity_penalty_out    = cap_pen_nxt;
    out_data_nxt.duration_penalty_out    = dur_pen_nxt;
    out_data_nxt.load_feasible_count     = load_ext[COUNT_OUT_W-1:0];
    out_data_nxt.duration_feasible_count = dur_ext[COUNT_OUT_W-1:0];
  end

  assign out_valid_nxt = accept || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/afp_checker.sv
// ----------------------------------------------------------------------------
// afp_checker
// Port-level checks of the adaptive feasibility penalty unit, bound to the
// top level.
// ----------------------------------------------------------------------------
module afp_checker #(
  parameter int WINDOW_LENGTH = afp_pkg::WINDOW_LENGTH_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input afp_pkg::afp_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input afp_pkg::afp_out_t out_data
);
  import afp_pkg::*;

  // Input is held back only by a result that waits.
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without a stalled result");

  // Every accepted item shows a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted item gave no result");

  // A stalled result stays put.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // Penalties always stay within floor and cap.
  a_pen_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.capacity_penalty_out >= PEN_FLOOR &&
                   out_data.capacity_penalty_out <= PEN_CAP &&
                   out_data.duration_penalty_out >= PEN_FLOOR &&
                   out_data.duration_penalty_out <= PEN_CAP))
    else $error("penalty out of range");

  // A restart refills both windows.
  a_restart_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.mode == MODE_RESTART) |=>
      (out_data.load_feasible_count == COUNT_OUT_W'(WINDOW_LENGTH) &&
       out_data.duration_feasible_count == COUNT_OUT_W'(WINDOW_LENGTH)))
    else $error("restart did not refill the windows");

endmodule

bind adaptive_feasibility_penalty_unit afp_checker #(
  .WINDOW_LENGTH (WINDOW_LENGTH)
) u_afp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: test/tb_adaptive_feasibility_penalty_unit.sv
// ----------------------------------------------------------------------------
// tb_adaptive_feasibility_penalty_unit
// Self-checking bench for the adaptive feasibility penalty unit. A short
// directed sequence hits the penalty bounds, the unused mode, restart and
// out-of-range initial penalties. Random phases then run under several
// register settings. Every accepted item is fed to a local copy of the
// window and penalty state, and each result is compared field by field.
// ----------------------------------------------------------------------------
module tb_adaptive_feasibility_penalty_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import afp_pkg::*;

  localparam int WIN = WINDOW_LENGTH_DEF;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  afp_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  afp_out_t              out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  adaptive_feasibility_penalty_unit #(.WINDOW_LENGTH(WIN)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Local copy of the block's registers and state.
  logic [TARGET_W-1:0] mdl_target;
  logic [PEN_W-1:0]    mdl_init_cap;
  logic [PEN_W-1:0]    mdl_init_dur;
  bit                  load_win [WIN];
  bit                  dur_win  [WIN];
  int unsigned         win_ptr;
  int unsigned         load_cnt;
  int unsigned         dur_cnt;
  logic [PEN_W-1:0]    cap_pen;
  logic [PEN_W-1:0]    dur_pen;

  afp_in_t  items_to_send [$];
  afp_out_t penalty_results_due [$];
  afp_out_t want;

  int errors        = 0;
  int results_seen  = 0;
  int send_idle_pct = 15;
  int recv_idle_pct = 15;
  int send_gap      = 0;
  int recv_gap      = 0;
  int hold_cnt      = 0;
  bit long_hold_done = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void refill_windows();
    for (int i = 0; i < WIN; i++) begin
      load_win[i] = 1'b1;
      dur_win[i]  = 1'b1;
    end
    win_ptr  = 0;
    load_cnt = WIN;
    dur_cnt  = WIN;
  endfunction

  function automatic logic [PEN_W-1:0] saturate_penalty(input logic [PEN_W-1:0] p);
    if (p > PEN_CAP) return PEN_CAP;
    if (p < PEN_FLOOR) return PEN_FLOOR;
    return p;
  endfunction

  // Exact integer form of the target +/- 5 percent window test.
  function automatic logic [PEN_W-1:0] scaled_penalty(input logic [PEN_W-1:0] pen,
                                                      input int unsigned ones);
    longint unsigned tw, c100, p, v;
    p    = pen;
    tw   = mdl_target * WIN;
    c100 = 100 * ones;
    if (c100 + 5 * WIN < tw && pen < PEN_CAP) begin
      v = (12 * p + 5) / 10;
      if (v > PEN_CAP) v = PEN_CAP;
      return PEN_W'(v);
    end
    if (c100 > tw + 5 * WIN && pen > PEN_FLOOR) begin
      v = (17 * p + 10) / 20;
      if (v < PEN_FLOOR) v = PEN_FLOOR;
      return PEN_W'(v);
    end
    return pen;
  endfunction

  function automatic void advance_penalty_state(input afp_in_t it);
    afp_out_t    r;
    int unsigned slot;
    case (it.mode)
      MODE_RECORD: begin
        slot = (win_ptr >= WIN) ? 0 : win_ptr;
        load_cnt = load_cnt - load_win[slot] + it.load_ok;
        dur_cnt  = dur_cnt - dur_win[slot] + it.duration_ok;
        load_win[slot] = it.load_ok;
        dur_win[slot]  = it.duration_ok;
        win_ptr = (slot + 1 >= WIN) ? 0 : slot + 1;
      end
      MODE_MANAGE: begin
        cap_pen = scaled_penalty(cap_pen, load_cnt);
        dur_pen = scaled_penalty(dur_pen, dur_cnt);
      end
      MODE_RESTART: begin
        refill_windows();
        cap_pen = saturate_penalty(mdl_init_cap);
        dur_pen = saturate_penalty(mdl_init_dur);
      end
      default: ;
    endcase
    r.capacity_penalty_out    = cap_pen;
    r.duration_penalty_out    = dur_pen;
    r.load_feasible_count     = COUNT_OUT_W'(load_cnt);
    r.duration_feasible_count = COUNT_OUT_W'(dur_cnt);
    penalty_results_due = {penalty_results_due, r};
  endfunction

  function automatic void queue_item(input logic [1:0] m, input bit l, input bit d);
    afp_in_t it;
    it.mode        = m;
    it.load_ok     = l;
    it.duration_ok = d;
    items_to_send = {items_to_send, it};
  endfunction

  function automatic afp_in_t random_item(input int load_pct, input int dur_pct);
    afp_in_t it;
    int      r;
    r = $urandom_range(0, 99);
    if (r < 68) it.mode = MODE_RECORD;
    else if (r < 93) it.mode = MODE_MANAGE;
    else if (r < 98) it.mode = MODE_RESTART;
    else it.mode = MODE_UNUSED;
    it.load_ok     = ($urandom_range(0, 99) < load_pct);
    it.duration_ok = ($urandom_range(0, 99) < dur_pct);
    return it;
  endfunction

  // Mostly legal initial penalties, sometimes below the floor or above the cap.
  function automatic logic [PEN_W-1:0] random_init_penalty();
    case ($urandom_range(0, 5))
      0: return PEN_W'($urandom);
      1: return PEN_W'($urandom_range(0, PEN_FLOOR));
      2: return PEN_W'($urandom_range(PEN_CAP, (1 << PEN_W) - 1));
      default: return PEN_W'($urandom_range(PEN_FLOOR, PEN_CAP));
    endcase
  endfunction

  task automatic write_config(input logic [TARGET_W-1:0] tgt,
                              input logic [PEN_W-1:0] cap0,
                              input logic [PEN_W-1:0] dur0);
    logic [PEN_W-TARGET_W-1:0] upper;
    upper = (PEN_W-TARGET_W)'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TARGET;
    cfg_wdata <= {upper, tgt};
    @(posedge clk);
    cfg_index <= CFG_INIT_CAP;
    cfg_wdata <= cap0;
    @(posedge clk);
    cfg_index <= CFG_INIT_DUR;
    cfg_wdata <= dur0;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (items_to_send.size() != 0 || in_valid || out_valid ||
           penalty_results_due.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // Sender: also mirrors register writes and predicts each accepted item.
  always @(posedge clk) begin
    if (!rst_n) begin
      mdl_target   = TARGET_RESET;
      mdl_init_cap = PEN_ONE;
      mdl_init_dur = PEN_ONE;
      refill_windows();
      cap_pen  = PEN_ONE;
      dur_pen  = PEN_ONE;
      send_gap = 0;
      in_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TARGET:   mdl_target   = cfg_wdata[TARGET_W-1:0];
          CFG_INIT_CAP: mdl_init_cap = cfg_wdata;
          CFG_INIT_DUR: mdl_init_dur = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) advance_penalty_state(in_data);

      if (in_valid && !in_ready) begin
        // Item still waiting: hold valid and payload.
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (items_to_send.size() != 0) begin
        in_data  <= items_to_send[0];
        items_to_send.delete(0);
        in_valid <= 1'b1;
        if ($urandom_range(0, 99) < send_idle_pct) send_gap = $urandom_range(1, 18);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // One long hold-off early in the random part so the input side backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (!long_hold_done && results_seen >= 300) begin
      hold_cnt       <= 400;
      long_hold_done <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Receiver and checker.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (penalty_results_due.size() == 0) begin
          report_mismatch("result arrived with none expected");
        end else begin
          want = penalty_results_due[0];
          penalty_results_due.delete(0);
          if (out_data.capacity_penalty_out !== want.capacity_penalty_out)
            report_mismatch($sformatf("capacity_penalty_out got %0d expected %0d",
                                      out_data.capacity_penalty_out,
                                      want.capacity_penalty_out));
          if (out_data.duration_penalty_out !== want.duration_penalty_out)
            report_mismatch($sformatf("duration_penalty_out got %0d expected %0d",
                                      out_data.duration_penalty_out,
                                      want.duration_penalty_out));
          if (out_data.load_feasible_count !== want.load_feasible_count)
            report_mismatch($sformatf("load_feasible_count got %0d expected %0d",
                                      out_data.load_feasible_count,
                                      want.load_feasible_count));
          if (out_data.duration_feasible_count !== want.duration_feasible_count)
            report_mismatch($sformatf("duration_feasible_count got %0d expected %0d",
                                      out_data.duration_feasible_count,
                                      want.duration_feasible_count));
        end
      end

      if (hold_cnt > 0) begin
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < recv_idle_pct) recv_gap = $urandom_range(1, 18);
      end
    end
  end

  initial begin
    int lp, dp;
    logic [TARGET_W-1:0] tgt;
    logic [PEN_W-1:0]    cap0, dur0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: unused mode, lowering from full windows, all flag pairs.
    queue_item(MODE_UNUSED, 1'b1, 1'b1);
    queue_item(MODE_MANAGE, 1'b0, 1'b0);
    queue_item(MODE_RECORD, 1'b0, 1'b0);
    queue_item(MODE_RECORD, 1'b1, 1'b1);
    queue_item(MODE_RECORD, 1'b0, 1'b1);
    queue_item(MODE_RECORD, 1'b1, 1'b0);
    queue_item(MODE_MANAGE, 1'b1, 1'b1);
    queue_item(MODE_RESTART, 1'b0, 1'b0);
    queue_item(MODE_RECORD, 1'b0, 1'b0);
    queue_item(MODE_UNUSED, 1'b0, 1'b0);
    wait_idle();

    // Target above 100, initial penalties beyond both ends of the range.
    write_config(TARGET_W'(127), {PEN_W{1'b1}}, '0);
    queue_item(MODE_RESTART, 1'b1, 1'b1);
    queue_item(MODE_MANAGE, 1'b0, 1'b0);
    queue_item(MODE_RECORD, 1'b1, 1'b1);
    wait_idle();

    // Zero target: capacity sits at the floor, duration starts at the cap.
    write_config('0, PEN_W'(1), PEN_CAP);
    queue_item(MODE_RESTART, 1'b0, 1'b0);
    queue_item(MODE_MANAGE, 1'b0, 1'b0);
    queue_item(MODE_MANAGE, 1'b1, 1'b0);
    queue_item(MODE_RECORD, 1'b0, 1'b0);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          tgt = '0; cap0 = {PEN_W{1'b1}}; dur0 = PEN_FLOOR; lp = 100; dp = 0;
        end
        1: begin
          tgt = TARGET_W'(100); cap0 = '0; dur0 = PEN_CAP; lp = 0; dp = 100;
        end
        default: begin
          tgt  = TARGET_W'($urandom_range(0, 127));
          cap0 = random_init_penalty();
          dur0 = random_init_penalty();
          lp   = $urandom_range(0, 100);
          dp   = $urandom_range(0, 100);
        end
      endcase
      if (ph == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = $urandom_range(0, 30);
        recv_idle_pct = $urandom_range(0, 30);
      end
      write_config(tgt, cap0, dur0);
      repeat (250) items_to_send = {items_to_send, random_item(lp, dp)};
      wait_idle();
    end

    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("** adaptive_feasibility_penalty_unit: PASSED **");
    end else begin
      $display("** adaptive_feasibility_penalty_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #7200000;
    $display("timeout waiting for results");
    $display("** adaptive_feasibility_penalty_unit: FAILED **");
    $finish;
  end

endmodule
